// ===== hdl/hypervector_majority_bundler_unit_macros.svh =====
`ifndef HYPERVECTOR_MAJORITY_BUNDLER_UNIT_MACROS_SVH
`define HYPERVECTOR_MAJORITY_BUNDLER_UNIT_MACROS_SVH

// Concurrent checks sampled on clk_i and disabled while rst_ni is low.

`define HMB_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`define HMB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

`define HMB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/hmb_pkg.sv =====
`default_nettype none

package hmb_pkg;

  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned DIM_BITS    = 1024;
  localparam int unsigned COUNT_BITS  = 11;
  localparam int unsigned NUM_WORDS   = DIM_BITS / WORD_BITS;
  localparam int unsigned IDX_BITS    = $clog2(NUM_WORDS);
  localparam int unsigned ROW_BITS    = WORD_BITS * COUNT_BITS;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX    = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] THRESH_RESET = COUNT_BITS'(512);

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2
  } hmb_op_e;

  typedef struct packed {
    logic [1:0]           func;
    logic [IDX_BITS-1:0]  word_index;
    logic [WORD_BITS-1:0] vote_bits;
  } hmb_in_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] majority_bits;
    logic [IDX_BITS-1:0]  read_index;
  } hmb_out_t;

  typedef struct packed {
    hmb_op_e              op;
    logic [IDX_BITS-1:0]  word_index;
    logic [WORD_BITS-1:0] vote_bits;
  } hmb_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/hmb_ram.sv =====
`default_nettype none

module hmb_ram #(
  parameter int unsigned WIDTH = 352,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/hmb_front.sv =====
`default_nettype none

module hmb_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire hmb_pkg::hmb_in_t  in_data_i,
  output logic                 cmd_valid_o,
  input  wire logic            cmd_ready_i,
  output hmb_pkg::hmb_cmd_t    cmd_data_o
);

  import hmb_pkg::*;

  logic     cmd_valid_q, cmd_valid_d;
  hmb_cmd_t cmd_q, cmd_d;
  hmb_op_e  dec_op;
  logic     dec_keep;
  logic     in_take;

  always_comb begin
    dec_op   = OP_CLEAR;
    dec_keep = 1'b1;
    case (in_data_i.func)
      FUNC_CLEAR: dec_op = OP_CLEAR;
      FUNC_ADD:   dec_op = OP_ADD;
      FUNC_READ:  dec_op = OP_READ;
      default:    dec_keep = 1'b0;
    endcase
  end

  // An unused function code is accepted and dropped here.
  assign in_ready_o = !cmd_valid_q || cmd_ready_i;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    cmd_valid_d = cmd_valid_q;
    cmd_d       = cmd_q;
    if (cmd_valid_q && cmd_ready_i) begin
      cmd_valid_d = 1'b0;
    end
    if (in_take) begin
      cmd_valid_d      = dec_keep;
      cmd_d.op         = dec_op;
      cmd_d.word_index = in_data_i.word_index;
      cmd_d.vote_bits  = in_data_i.vote_bits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = cmd_valid_q;
  assign cmd_data_o  = cmd_q;

endmodule

`default_nettype wire

// ===== hdl/hmb_queue.sv =====
`default_nettype none

module hmb_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire hmb_pkg::hmb_cmd_t push_data_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output hmb_pkg::hmb_cmd_t      pop_data_o
);

  import hmb_pkg::*;

  `include "hypervector_majority_bundler_unit_macros.svh"

  localparam int unsigned PTR_BITS = $clog2(QUEUE_DEPTH);

  hmb_cmd_t              entry_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0]  count_q, count_d;
  logic                  push, pop;

  assign push_ready_o = count_q != QCNT_BITS'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  `HMB_ASSERT_ALWAYS(a_count_bound, count_q <= QCNT_BITS'(QUEUE_DEPTH), "Queue count exceeds depth.")
  `HMB_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "Queue count did not grow on a push.")
  `HMB_ASSERT_NEXT(a_count_down, pop && !push, count_q == $past(count_q) - 1'b1, "Queue count did not shrink on a pop.")

endmodule

`default_nettype wire

// ===== hdl/hmb_back.sv =====
`default_nettype none

module hmb_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [hmb_pkg::COUNT_BITS-1:0] thresh_i,
  input  wire logic                           cmd_valid_i,
  output logic                                cmd_ready_o,
  input  wire hmb_pkg::hmb_cmd_t              cmd_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output hmb_pkg::hmb_out_t                   out_data_o
);

  import hmb_pkg::*;

  `include "hypervector_majority_bundler_unit_macros.svh"

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                  state_q, state_d;
  logic [NUM_WORDS-1:0]  word_valid_q, word_valid_d;
  hmb_op_e               op_q;
  logic [IDX_BITS-1:0]   idx_q;
  logic [WORD_BITS-1:0]  bits_q;
  logic                  out_valid_q, out_valid_d;
  hmb_out_t              out_q;

  logic                  pop, ram_re, ram_we, out_load;
  logic [ROW_BITS-1:0]   ram_rdata, row, row_next;
  logic [WORD_BITS-1:0]  maj;
  logic [COUNT_BITS-1:0] cnt;

  hmb_ram #(
    .WIDTH(ROW_BITS),
    .DEPTH(NUM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (row_next),
    .re_i    (ram_re),
    .raddr_i (cmd_data_i.word_index),
    .rdata_o (ram_rdata)
  );

  assign cmd_ready_o = state_q == S_IDLE;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign ram_re      = pop && (cmd_data_i.op != OP_CLEAR);
  assign ram_we      = (state_q == S_EXEC) && (op_q == OP_ADD);
  assign out_load    = (state_q == S_EXEC) && (op_q == OP_READ) && (!out_valid_q || out_ready_i);

  // A word whose flag is low has been cleared and reads as all zero.
  assign row = word_valid_q[idx_q] ? ram_rdata : '0;

  always_comb begin
    row_next = row;
    maj      = '0;
    cnt      = '0;
    for (int unsigned j = 0; j < WORD_BITS; j++) begin
      cnt    = row[j*COUNT_BITS +: COUNT_BITS];
      maj[j] = cnt > thresh_i;
      if (bits_q[j] && (cnt != COUNT_MAX)) begin
        row_next[j*COUNT_BITS +: COUNT_BITS] = cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    word_valid_d = word_valid_q;
    out_valid_d  = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (pop) begin
          if (cmd_data_i.op == OP_CLEAR) begin
            word_valid_d[cmd_data_i.word_index] = 1'b0;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (ram_we) begin
          word_valid_d[idx_q] = 1'b1;
          state_d             = S_IDLE;
        end
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      word_valid_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      word_valid_q <= word_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      op_q   <= cmd_data_i.op;
      idx_q  <= cmd_data_i.word_index;
      bits_q <= cmd_data_i.vote_bits;
    end
    if (out_load) begin
      out_q.majority_bits <= maj;
      out_q.read_index    <= idx_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `HMB_ASSERT_IMPL(a_no_overwrite, out_load, !out_valid_q || out_ready_i, "Pending result overwritten.")
  `HMB_ASSERT_NEXT(a_exec_after_rmw, pop && (cmd_data_i.op != OP_CLEAR), state_q == S_EXEC, "Read-modify-write did not start.")
  `HMB_ASSERT_NEXT(a_flag_after_add, ram_we, word_valid_q[$past(idx_q)], "Word flag not set after an add.")
  `HMB_ASSERT_NEXT(a_flag_after_clear, pop && (cmd_data_i.op == OP_CLEAR), !word_valid_q[$past(cmd_data_i.word_index)], "Word flag not dropped after a clear.")

endmodule

`default_nettype wire

// ===== hdl/hypervector_majority_bundler_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o    in_data_i  (hmb_in_t)
// out       output     out_valid_o / out_ready_i  out_data_o (hmb_out_t)
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_data_i (vote threshold)
//
// The front stage takes one input transaction per cycle until the two-entry queue is full.
// A clear is done in the idle state; an add or a read moves to the execute state for its
// counter row, read from the row memory through its registered read; an add writes it back.
// A read waits in the back end while its output register still holds an untaken result.
// Reset zeroes all counters at once through per-word valid flags, with no clearing pass.
// The threshold resets to 512; configuration writes are taken in every cycle.

module hypervector_majority_bundler_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire hmb_pkg::hmb_in_t               in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output hmb_pkg::hmb_out_t                   out_data_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [hmb_pkg::COUNT_BITS-1:0] cfg_data_i
);

  import hmb_pkg::*;

  logic [COUNT_BITS-1:0] thresh_q;
  logic                  f_valid, f_ready, b_valid, b_ready;
  hmb_cmd_t              f_cmd, b_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thresh_q <= cfg_data_i;
    end
  end

  hmb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_data_o  (f_cmd)
  );

  hmb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_cmd)
  );

  hmb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .thresh_i    (thresh_q),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_data_i  (b_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
